### hw/rtl/tkst_pkg.sv
// Shared types and constants for the top-k score table.
// No dependencies; imported by tkst_cell and top_k_score_table_core.
package tkst_pkg;

   localparam int SCORE_BITS = 32;
   localparam int IN_TAG_BITS = 32;
   localparam int RANK_BITS = 4;

   localparam logic OP_CHECK = 1'b0;
   localparam logic OP_INSERT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CMP  = 3'b010,
      ST_DEC  = 3'b100
   } state_type;

   typedef struct packed {
      logic cmp_en;
      logic ins_en;
   } cell_ctrl_type;

   typedef struct packed {
      logic dup;
      logic ge;
   } cell_flag_type;

endpackage

### hw/rtl/top_k_score_table_core.sv
// Top-k score table: keeps up to TABLE_DEPTH (tag, score) pairs sorted by descending score
// and answers a check or an insert for each request beat. Every request passes through
// a compare state, in which all cells compare their entry with the key at once, and a
// decide state, in which the cells shift; the response is on the ports after it. busy is
// high in both states, so a new request can be taken at the earliest in the cycle of the
// previous response. The response strobe is high for one cycle, the first cycle with busy
// low again, and must be taken then: there is no back-pressure on the response side.
// Only the low TAG_BITS bits of the tag are stored and compared. No clearing pass.
// Depends on tkst_pkg and tkst_cell.
module top_k_score_table_core import tkst_pkg::*; #(
   parameter int TABLE_DEPTH = 16,
   parameter int TAG_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_opcode,
   input  logic [IN_TAG_BITS-1:0]       req_owner_tag,
   input  logic signed [SCORE_BITS-1:0] req_score,
   output logic                         rsp_strobe,
   output logic                         rsp_accepted,
   output logic [RANK_BITS-1:0]         rsp_rank
);

   localparam int CNT_BITS = $clog2(TABLE_DEPTH + 1);

   state_type                    state_ff;
   state_type                    state_in;
   logic [CNT_BITS-1:0]          count_ff;
   logic [CNT_BITS-1:0]          count_in;
   logic                         key_op_ff;
   logic [TAG_BITS-1:0]          key_tag_ff;
   logic signed [SCORE_BITS-1:0] key_score_ff;
   logic                         rsp_strobe_ff;
   logic                         rsp_accepted_ff;
   logic [RANK_BITS-1:0]         rsp_rank_ff;
   logic                         rsp_strobe_in;
   logic                         rsp_accepted_in;
   logic [RANK_BITS-1:0]         rsp_rank_in;

   cell_ctrl_type                ctrl;
   cell_flag_type                flags     [TABLE_DEPTH];
   logic [TAG_BITS-1:0]          cell_tags [TABLE_DEPTH];
   logic signed [SCORE_BITS-1:0] cell_scores [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]       dup_vec;
   logic [TABLE_DEPTH-1:0]       ge_vec;
   logic                         take;
   logic                         full;
   logic                         qualify;
   logic [RANK_BITS-1:0]         pos;
   logic                         pos_found;

   assign take = start && !busy;
   assign busy = (state_ff != ST_IDLE);
   assign full = (count_ff == CNT_BITS'(TABLE_DEPTH));

   always_ff @(posedge clock) begin
      if (take) begin
         key_op_ff    <= req_opcode;
         key_tag_ff   <= TAG_BITS'(req_owner_tag);
         key_score_ff <= req_score;
      end
   end

   assign ctrl.cmp_en = (state_ff == ST_CMP);
   assign ctrl.ins_en = (state_ff == ST_DEC) && qualify && (key_op_ff == OP_INSERT);

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      logic                         prev_ge;
      logic [TAG_BITS-1:0]          prev_tag;
      logic signed [SCORE_BITS-1:0] prev_score;

      if (i == 0) begin : g_head
         assign prev_ge    = 1'b1;
         assign prev_tag   = key_tag_ff;
         assign prev_score = key_score_ff;
      end else begin : g_body
         assign prev_ge    = flags[i-1].ge;
         assign prev_tag   = cell_tags[i-1];
         assign prev_score = cell_scores[i-1];
      end

      tkst_cell #(
         .TAG_BITS (TAG_BITS)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .key_tag    (key_tag_ff),
         .key_score  (key_score_ff),
         .occupied   (count_ff > CNT_BITS'(i)),
         .prev_ge    (prev_ge),
         .prev_tag   (prev_tag),
         .prev_score (prev_score),
         .flag       (flags[i]),
         .tag        (cell_tags[i]),
         .score      (cell_scores[i])
      );

      assign dup_vec[i] = flags[i].dup;
      assign ge_vec[i]  = flags[i].ge;
   end

   // ge flags form a thermometer; the first clear one is the insert slot
   always_comb begin
      pos       = '0;
      pos_found = 1'b0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (!pos_found && !ge_vec[i]) begin
            pos       = RANK_BITS'(i);
            pos_found = 1'b1;
         end
      end
   end

   assign qualify = !(|dup_vec) && (key_score_ff > 0) && (!full || !ge_vec[TABLE_DEPTH-1]);

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      rsp_strobe_in   = 1'b0;
      rsp_accepted_in = rsp_accepted_ff;
      rsp_rank_in     = rsp_rank_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            state_in = ST_DEC;
         end
         ST_DEC: begin
            state_in        = ST_IDLE;
            rsp_strobe_in   = 1'b1;
            rsp_accepted_in = qualify;
            rsp_rank_in     = ctrl.ins_en ? pos : '0;
            if (ctrl.ins_en && !full) begin
               count_in = count_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_accepted_ff <= rsp_accepted_in;
      rsp_rank_ff     <= rsp_rank_in;
   end

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_accepted = rsp_accepted_ff;
   assign rsp_rank     = rsp_rank_ff;

   a_strobe_after_dec: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ST_DEC))
      else $error("response beat without a decide cycle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      (ctrl.ins_en && !full) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("insert on a non-full table did not grow the count");

   a_reject_rank: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_accepted) |-> (rsp_rank == '0))
      else $error("rejected beat with non-zero rank");

   a_insert_slot: assert property (@(posedge clock) disable iff (reset)
      ctrl.ins_en |-> pos_found)
      else $error("insert without a free slot");

endmodule

### hw/rtl/tkst_cell.sv
// One slot of the sorted table: holds a tag and score, compares them against the key
// and on insert either holds, takes the key or takes its upper neighbour's entry.
// Depends on tkst_pkg.
module tkst_cell import tkst_pkg::*; #(
   parameter int TAG_BITS = 32
) (
   input  logic                         clock,
   input  cell_ctrl_type                ctrl,
   input  logic [TAG_BITS-1:0]          key_tag,
   input  logic signed [SCORE_BITS-1:0] key_score,
   input  logic                         occupied,
   input  logic                         prev_ge,
   input  logic [TAG_BITS-1:0]          prev_tag,
   input  logic signed [SCORE_BITS-1:0] prev_score,
   output cell_flag_type                flag,
   output logic [TAG_BITS-1:0]          tag,
   output logic signed [SCORE_BITS-1:0] score
);

   logic [TAG_BITS-1:0]          tag_ff;
   logic [TAG_BITS-1:0]          tag_in;
   logic signed [SCORE_BITS-1:0] score_ff;
   logic signed [SCORE_BITS-1:0] score_in;
   cell_flag_type                flag_ff;
   cell_flag_type                flag_in;

   always_comb begin
      flag_in = flag_ff;
      if (ctrl.cmp_en) begin
         flag_in.dup = occupied && (tag_ff == key_tag) && (score_ff == key_score);
         flag_in.ge  = occupied && (score_ff >= key_score);
      end
   end

   always_comb begin
      tag_in   = tag_ff;
      score_in = score_ff;
      if (ctrl.ins_en && !flag_ff.ge) begin
         if (prev_ge) begin
            tag_in   = key_tag;
            score_in = key_score;
         end else begin
            tag_in   = prev_tag;
            score_in = prev_score;
         end
      end
   end

   always_ff @(posedge clock) begin
      flag_ff  <= flag_in;
      tag_ff   <= tag_in;
      score_ff <= score_in;
   end

   assign flag  = flag_ff;
   assign tag   = tag_ff;
   assign score = score_ff;

endmodule
